@@ src/hrcm_pkg.sv @@
// Shared types, constants and helper functions for the hue range color mask.
// Used by the front end, the divider cells and the top level. No dependencies.
package hrcm_pkg;

  // Fixed-point format of the input channels.
  localparam int CHANNEL_FRAC_BITS = 12;
  localparam int IN_W              = 16;
  localparam int LEVEL_W           = 8;
  localparam int PROD_W            = IN_W - 1 + LEVEL_W;

  // Divider sizing: the hue numerator stays below 180 * 255.
  localparam int PART_W   = 16;
  localparam int QUO_BITS = 8;
  localparam int DEG_W    = 9;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_SELECT  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

  // Color codes.
  localparam logic [2:0] COLOR_RED     = 3'd0;
  localparam logic [2:0] COLOR_ORANGE  = 3'd1;
  localparam logic [2:0] COLOR_YELLOW  = 3'd2;
  localparam logic [2:0] COLOR_GREEN   = 3'd3;
  localparam logic [2:0] COLOR_CYAN    = 3'd4;
  localparam logic [2:0] COLOR_BLUE    = 3'd5;
  localparam logic [2:0] COLOR_MAGENTA = 3'd6;
  localparam logic [2:0] COLOR_UNKNOWN = 3'd7;

  localparam logic [2:0] COLOR_RESET   = COLOR_RED;
  localparam logic [2:0] CHANNEL_RESET = 3'd3;
  localparam logic [2:0] MIN_CHANNELS  = 3'd3;

  // Red also covers the top of the hue circle.
  localparam logic [DEG_W-1:0] RED_WRAP_LO_DEG = 9'd350;

  typedef logic [LEVEL_W-1:0]  level_t;
  typedef logic [PART_W-1:0]   part_t;
  typedef logic [QUO_BITS-1:0] quo_t;
  typedef logic [DEG_W-1:0]    deg_t;

  // Data word handed from cell to cell along the divider chain.
  typedef struct packed {
    part_t  part;
    quo_t   quo;
    level_t divisor;
  } div_word_t;

  // Control bits that travel alongside the data word.
  typedef struct packed {
    logic valid;
    logic gray;
  } div_tag_t;

  // Lower end of a color's hue range in degrees.
  function automatic deg_t range_lo(logic [2:0] color);
    deg_t lo;
    unique case (color)
      COLOR_RED:     lo = 9'd0;
      COLOR_ORANGE:  lo = 9'd10;
      COLOR_YELLOW:  lo = 9'd40;
      COLOR_GREEN:   lo = 9'd70;
      COLOR_CYAN:    lo = 9'd170;
      COLOR_BLUE:    lo = 9'd200;
      COLOR_MAGENTA: lo = 9'd270;
      default:       lo = 9'd0;
    endcase
    return lo;
  endfunction

  // Upper end of a color's hue range in degrees.
  function automatic deg_t range_hi(logic [2:0] color);
    deg_t hi;
    unique case (color)
      COLOR_RED:     hi = 9'd10;
      COLOR_ORANGE:  hi = 9'd40;
      COLOR_YELLOW:  hi = 9'd70;
      COLOR_GREEN:   hi = 9'd170;
      COLOR_CYAN:    hi = 9'd200;
      COLOR_BLUE:    hi = 9'd270;
      COLOR_MAGENTA: hi = 9'd350;
      default:       hi = 9'd0;
    endcase
    return hi;
  endfunction

endpackage

@@ src/hrcm_if.sv @@
// Valid/ready stream interfaces for pixels in and mask results out.
// Depends on hrcm_pkg for field widths.
interface hrcm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [hrcm_pkg::IN_W-1:0]    red_level;
  logic signed [hrcm_pkg::IN_W-1:0]    green_level;
  logic signed [hrcm_pkg::IN_W-1:0]    blue_level;

  modport source (output valid, output red_level, output green_level, output blue_level,
                  input ready);
  modport sink   (input valid, input red_level, input green_level, input blue_level,
                  output ready);
endinterface

interface hrcm_out_if;
  logic                     valid;
  logic                     ready;
  logic                     mask_bit;
  logic [7:0]               hue_half_degrees;

  modport source (output valid, output mask_bit, output hue_half_degrees, input ready);
  modport sink   (input valid, input mask_bit, input hue_half_degrees, output ready);
endinterface

@@ src/hrcm_front.sv @@
// Front end: channel scaling to 8-bit levels, max/min and hue numerator.
// Three register stages feeding the divider chain. Depends on hrcm_pkg.
module hrcm_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [hrcm_pkg::IN_W-1:0]  red_level,
  input  logic signed [hrcm_pkg::IN_W-1:0]  green_level,
  input  logic signed [hrcm_pkg::IN_W-1:0]  blue_level,
  output hrcm_pkg::div_tag_t                tag_out,
  output hrcm_pkg::div_word_t               word_out
);

  localparam logic [1:0] SECT_R = 2'd0;
  localparam logic [1:0] SECT_G = 2'd1;
  localparam logic [1:0] SECT_B = 2'd2;

  // Scale one channel by 255 / full scale, clamping to 0..255.
  function automatic hrcm_pkg::level_t to_level(logic signed [hrcm_pkg::IN_W-1:0] x);
    logic [hrcm_pkg::PROD_W-1:0] prod;
    logic [hrcm_pkg::PROD_W-1:0] shf;
    hrcm_pkg::level_t            lvl;
    prod = hrcm_pkg::PROD_W'(x[hrcm_pkg::IN_W-2:0]) * hrcm_pkg::PROD_W'(255);
    shf  = prod >> hrcm_pkg::CHANNEL_FRAC_BITS;
    if (x[hrcm_pkg::IN_W-1] || x == '0) begin
      lvl = '0;
    end else if (shf > hrcm_pkg::PROD_W'(255)) begin
      lvl = '1;
    end else begin
      lvl = hrcm_pkg::LEVEL_W'(shf);
    end
    return lvl;
  endfunction

  // Stage 1: levels.
  logic             v1_r;
  hrcm_pkg::level_t r1_r, g1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r <= to_level(red_level);
      g1_r <= to_level(green_level);
      b1_r <= to_level(blue_level);
    end
  end

  // Stage 2: max, min, sector and channel difference.
  hrcm_pkg::level_t    mx, mn;
  logic [1:0]          sect_nxt;
  logic signed [8:0]   diff_nxt;

  always_comb begin
    mx = r1_r;
    mn = r1_r;
    if (g1_r > mx) mx = g1_r;
    if (b1_r > mx) mx = b1_r;
    if (g1_r < mn) mn = g1_r;
    if (b1_r < mn) mn = b1_r;
    if (mx == r1_r) begin
      sect_nxt = SECT_R;
      diff_nxt = 9'(g1_r) - 9'(b1_r);
    end else if (mx == g1_r) begin
      sect_nxt = SECT_G;
      diff_nxt = 9'(b1_r) - 9'(r1_r);
    end else begin
      sect_nxt = SECT_B;
      diff_nxt = 9'(r1_r) - 9'(g1_r);
    end
  end

  logic              v2_r;
  logic [1:0]        sect2_r;
  logic signed [8:0] diff2_r;
  hrcm_pkg::level_t  d2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sect2_r <= sect_nxt;
      diff2_r <= diff_nxt;
      d2_r    <= mx - mn;
    end
  end

  // Stage 3: numerator in half-degree units times d, wrapped to be non-negative.
  logic signed [16:0] diff_x, d_x, k_x, n_raw, n_adj;

  always_comb begin
    case (sect2_r)
      SECT_R:  k_x = 17'sd0;
      SECT_G:  k_x = 17'sd60;
      SECT_B:  k_x = 17'sd120;
      default: k_x = 17'sd0;
    endcase
    diff_x = 17'(diff2_r);
    d_x    = signed'(17'(d2_r));
    n_raw  = diff_x * 17'sd30 + d_x * k_x;
    n_adj  = (n_raw < 0) ? n_raw + d_x * 17'sd180 : n_raw;
  end

  logic               v3_r;
  logic               gray3_r;
  hrcm_pkg::part_t    n3_r;
  hrcm_pkg::level_t   d3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray3_r <= (d2_r == '0);
      n3_r    <= hrcm_pkg::PART_W'(n_adj);
      d3_r    <= d2_r;
    end
  end

  assign tag_out.valid    = v3_r;
  assign tag_out.gray     = gray3_r;
  assign word_out.part    = n3_r;
  assign word_out.quo     = '0;
  assign word_out.divisor = d3_r;

endmodule

@@ src/hrcm_div_cell.sv @@
// One cell of the restoring divider chain: settles one quotient bit per item.
// Depends on hrcm_pkg for the word and tag structs.
module hrcm_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [2:0]          bit_idx,
  input  hrcm_pkg::div_tag_t  tag_in,
  input  hrcm_pkg::div_word_t word_in,
  output hrcm_pkg::div_tag_t  tag_out,
  output hrcm_pkg::div_word_t word_out
);

  hrcm_pkg::part_t     shifted;
  logic                ge;
  hrcm_pkg::div_word_t word_nxt;
  hrcm_pkg::div_word_t word_r;
  logic                valid_r;
  logic                gray_r;

  // Compare the partial remainder with the divisor at this bit weight.
  always_comb begin
    shifted           = hrcm_pkg::PART_W'(word_in.divisor) << bit_idx;
    ge                = (word_in.part >= shifted);
    word_nxt.divisor  = word_in.divisor;
    word_nxt.part     = ge ? word_in.part - shifted : word_in.part;
    word_nxt.quo      = word_in.quo | (hrcm_pkg::QUO_BITS'(ge) << bit_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= tag_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gray_r <= tag_in.gray;
      word_r <= word_nxt;
    end
  end

  assign tag_out.valid = valid_r;
  assign tag_out.gray  = gray_r;
  assign word_out      = word_r;

endmodule

@@ src/hue_range_color_mask_top.sv @@
// Top level of the hue range color mask: config registers, front end,
// divider cell chain, rounding and range test. Depends on hrcm_pkg, hrcm_if,
// hrcm_front and hrcm_div_cell.
//
//   Channel   Direction  Payload
//   in_pix    in         red_level, green_level, blue_level (signed 16 bits)
//   out_mask  out        mask_bit (1 bit), hue_half_degrees (8 bits)
//   cfg_*     in         cfg_we, cfg_index (2 bits), cfg_wdata (3 bits)
//
// One pixel is accepted per cycle unless the pipeline holds. Twelve register
// stages (three front stages, eight divider cells with one quotient bit each,
// and the output register) carry an item; the first loads at the input
// transfer edge, and a result is offered on out_mask from the output register.
// Reset clears the stage valid bits and loads color red and three channels.
// When a result waits and out_mask.ready is low the whole pipeline holds.
module hue_range_color_mask_top (
  input  logic                                   clk,
  input  logic                                   rst_n,
  hrcm_in_if.sink                                in_pix,
  hrcm_out_if.source                             out_mask,
  input  logic                                   cfg_we,
  input  logic [hrcm_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [hrcm_pkg::CFG_DATA_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [2:0] color_sel_r;
  logic [2:0] chan_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_sel_r <= hrcm_pkg::COLOR_RESET;
      chan_cnt_r  <= hrcm_pkg::CHANNEL_RESET;
    end else if (cfg_we) begin
      if (cfg_index == hrcm_pkg::CFG_COLOR_SELECT) begin
        color_sel_r <= cfg_wdata;
      end
      if (cfg_index == hrcm_pkg::CFG_CHANNEL_COUNT) begin
        chan_cnt_r <= cfg_wdata;
      end
    end
  end

  // The pipeline advances whenever the output register is free or drains.
  logic out_valid_r;
  logic en;

  assign en           = !out_valid_r || out_mask.ready;
  assign in_pix.ready = en;

  // Front end and divider chain.
  hrcm_pkg::div_tag_t  tag_chain  [hrcm_pkg::QUO_BITS+1];
  hrcm_pkg::div_word_t word_chain [hrcm_pkg::QUO_BITS+1];

  hrcm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (in_pix.valid),
    .red_level   (in_pix.red_level),
    .green_level (in_pix.green_level),
    .blue_level  (in_pix.blue_level),
    .tag_out     (tag_chain[0]),
    .word_out    (word_chain[0])
  );

  for (genvar k = 0; k < hrcm_pkg::QUO_BITS; k++) begin : g_cell
    hrcm_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .bit_idx  (3'(hrcm_pkg::QUO_BITS - 1 - k)),
      .tag_in   (tag_chain[k]),
      .word_in  (word_chain[k]),
      .tag_out  (tag_chain[k+1]),
      .word_out (word_chain[k+1])
    );
  end

  hrcm_pkg::div_tag_t  last_tag;
  hrcm_pkg::div_word_t last_word;

  assign last_tag  = tag_chain[hrcm_pkg::QUO_BITS];
  assign last_word = word_chain[hrcm_pkg::QUO_BITS];

  // Round half to even using the remainder, then test the degree range.
  logic [16:0]        rem_x2, div_x;
  logic               round_up;
  hrcm_pkg::quo_t     hue;
  hrcm_pkg::deg_t     deg;
  logic               hit;
  logic               few_chan;
  logic               mask_nxt;
  hrcm_pkg::quo_t     hue_nxt;

  always_comb begin
    rem_x2   = 17'(last_word.part) << 1;
    div_x    = 17'(last_word.divisor);
    round_up = (rem_x2 > div_x) || ((rem_x2 == div_x) && last_word.quo[0]);
    hue      = last_tag.gray ? '0 : last_word.quo + hrcm_pkg::QUO_BITS'(round_up);
    deg      = {hue, 1'b0};
    hit      = (color_sel_r != hrcm_pkg::COLOR_UNKNOWN)
               && (deg >= hrcm_pkg::range_lo(color_sel_r))
               && (deg <= hrcm_pkg::range_hi(color_sel_r));
    if ((color_sel_r == hrcm_pkg::COLOR_RED) && (deg >= hrcm_pkg::RED_WRAP_LO_DEG)) begin
      hit = 1'b1;
    end
    few_chan = (chan_cnt_r < hrcm_pkg::MIN_CHANNELS);
    mask_nxt = few_chan ? 1'b0 : hit;
    hue_nxt  = few_chan ? '0 : hue;
  end

  // Output register.
  logic           mask_r;
  hrcm_pkg::quo_t hue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mask_r <= mask_nxt;
      hue_r  <= hue_nxt;
    end
  end

  assign out_mask.valid            = out_valid_r;
  assign out_mask.mask_bit         = mask_r;
  assign out_mask.hue_half_degrees = hue_r;

  // The hue never leaves the half-degree circle.
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (hue_r <= 8'd180))
    else $error("hue result above 180");

  // A set mask bit needs enough channels and a known color.
  a_mask_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && mask_r) |->
      ((chan_cnt_r >= hrcm_pkg::MIN_CHANNELS) && (color_sel_r != hrcm_pkg::COLOR_UNKNOWN)))
    else $error("mask bit set with too few channels or unknown color");

  // After the last cell the remainder is below the divisor for a colored pixel.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (last_tag.valid && !last_tag.gray) |->
      (last_word.part < hrcm_pkg::PART_W'(last_word.divisor)))
    else $error("divider remainder not below divisor");

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r)
    else $error("result valid right after reset");

  // A held result keeps its payload while the pipeline is stalled.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_mask.ready) |=> ($stable(hue_r) && $stable(mask_r)))
    else $error("stalled result changed");

endmodule

@@ test/hue_range_color_mask_top_test.sv @@
// Self-checking testbench for hue_range_color_mask_top: directed corner pixels,
// every color, low channel counts, a long random sweep with idling and backpressure,
// an output hold and a full-rate run. Depends on hrcm_pkg, hrcm_if and the top RTL.
module hue_range_color_mask_top_test;
  import hrcm_pkg::*;

  typedef logic signed [IN_W-1:0] channel_t;

  // One expected result: the mask bit and the hue in half degrees.
  typedef struct packed {
    logic       hit;
    logic [7:0] hue;
  } mask_result_t;

  // Register stages of the pipeline; sets the extra wait in settle_pipeline.
  localparam int PIPE_LATENCY = 12;

  // Register indexes that decode to no register.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Degree bands of the seven named colors, indexed by color code.
  localparam logic [6:0][8:0] BAND_LOW_DEG =
    {9'd270, 9'd200, 9'd170, 9'd70, 9'd40, 9'd10, 9'd0};
  localparam logic [6:0][8:0] BAND_HIGH_DEG =
    {9'd350, 9'd270, 9'd200, 9'd170, 9'd70, 9'd40, 9'd10};
  localparam int FULL_CIRCLE_DEG = 360;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  hrcm_in_if  in_pix ();
  hrcm_out_if out_mask ();

  hue_range_color_mask_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .out_mask  (out_mask),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register values as the block should hold them.
  logic [CFG_DATA_W-1:0] color_now;
  logic [CFG_DATA_W-1:0] channels_now;

  mask_result_t pending_masks [$];
  int           mismatch_count;
  bit           gaps_on;
  bit           stalls_on;
  int           hold_request;
  int           stall_left;

  // Clock with a period of 2.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #1000000;
    $display("Mismatches found");
    $finish;
  end

  // Channel value to 8-bit level: floor(x * 255 / full scale), clamped.
  function automatic level_t pixel_level(channel_t x);
    int p;
    if (x <= 0) return '0;
    p = (int'(x) * 255) >>> CHANNEL_FRAC_BITS;
    return (p > 255) ? 8'd255 : p[7:0];
  endfunction

  // 8-bit HLS hue in half degrees, rounded half to even.
  function automatic logic [7:0] hue_half_of(level_t r, level_t g, level_t b);
    int ri, gi, bi, top, bottom, span, num, quo, rem;
    ri = r;
    gi = g;
    bi = b;
    top = ri;
    bottom = ri;
    if (gi > top) top = gi;
    if (bi > top) top = bi;
    if (gi < bottom) bottom = gi;
    if (bi < bottom) bottom = bi;
    span = top - bottom;
    if (span == 0) return 8'd0;
    // Red wins a tie for the maximum, then green.
    if (top == ri) num = 30 * (gi - bi);
    else if (top == gi) num = 30 * (bi - ri) + 60 * span;
    else num = 30 * (ri - gi) + 120 * span;
    if (num < 0) num += 180 * span;
    quo = num / span;
    rem = num % span;
    if (2 * rem > span || (2 * rem == span && quo[0])) quo++;
    return quo[7:0];
  endfunction

  // Expected result of one pixel under the current register values.
  function automatic mask_result_t predict_mask(channel_t r, channel_t g, channel_t b);
    mask_result_t res;
    int deg;
    res = '0;
    if (channels_now < MIN_CHANNELS) return res;
    res.hue = hue_half_of(pixel_level(r), pixel_level(g), pixel_level(b));
    deg = 2 * int'(res.hue);
    if (color_now != COLOR_UNKNOWN) begin
      if (deg >= int'(BAND_LOW_DEG[color_now]) && deg <= int'(BAND_HIGH_DEG[color_now]))
        res.hit = 1'b1;
      if (color_now == COLOR_RED && deg >= int'(RED_WRAP_LO_DEG) && deg <= FULL_CIRCLE_DEG)
        res.hit = 1'b1;
    end
    return res;
  endfunction

  // Offer one pixel, possibly after an idle burst, and wait for its transfer.
  // Valid stays high afterwards so back-to-back pixels need no extra cycle.
  task automatic send_pixel(input channel_t r, input channel_t g, input channel_t b);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid       <= 1'b1;
    in_pix.red_level   <= r;
    in_pix.green_level <= g;
    in_pix.blue_level  <= b;
    @(posedge clk);
    while (!in_pix.ready) @(posedge clk);
    pending_masks.push_back(predict_mask(r, g, b));
  endtask

  // Stop offering pixels and wait until every result has come out.
  task automatic settle_pipeline();
    in_pix.valid <= 1'b0;
    while (pending_masks.size() != 0) @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);
  endtask

  // Write one register; the block must be idle.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_COLOR_SELECT:  color_now = value;
      CFG_CHANNEL_COUNT: channels_now = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Random pixel: mostly in the useful range, with noise, near-gray, ties and extremes.
  task automatic pick_pixel(output channel_t r, output channel_t g, output channel_t b);
    channel_t ch [0:2];
    int kind, base, i;
    kind = $urandom_range(0, 99);
    base = $urandom_range(0, 4112);
    for (i = 0; i < 3; i++) begin
      if (kind < 55 || (kind >= 82 && kind < 95)) ch[i] = 16'($urandom_range(0, 4200));
      else if (kind < 70) ch[i] = 16'($urandom());
      else if (kind < 82) ch[i] = 16'(base + $urandom_range(0, 48));
      else begin
        case ($urandom_range(0, 6))
          0: ch[i] = -16'sd32768;
          1: ch[i] = -16'sd1;
          2: ch[i] = 16'sd0;
          3: ch[i] = 16'sd1;
          4: ch[i] = 16'sd4095;
          5: ch[i] = 16'sd4096;
          default: ch[i] = 16'sd32767;
        endcase
      end
    end
    // Two equal channels exercise the tie order of the maximum.
    if (kind >= 82 && kind < 95) begin
      i = $urandom_range(0, 2);
      ch[(i + 1) % 3] = ch[i];
    end
    r = ch[0];
    g = ch[1];
    b = ch[2];
  endtask

  // Corner pixels under the reset values: red, three channels.
  task automatic test_reset_defaults();
    send_pixel(16'sd0, 16'sd0, 16'sd0);
    send_pixel(16'sd4096, 16'sd4096, 16'sd4096);
    send_pixel(16'sd32767, 16'sd32767, 16'sd32767);
    send_pixel(-16'sd32768, 16'sd32767, -16'sd1);
    send_pixel(16'sd1, 16'sd16, 16'sd17);
    send_pixel(16'sd4096, 16'sd0, 16'sd0);
    send_pixel(16'sd0, 16'sd4096, 16'sd0);
    send_pixel(16'sd0, 16'sd0, 16'sd4096);
    send_pixel(16'sd4096, 16'sd4096, 16'sd0);
    send_pixel(16'sd0, 16'sd4096, 16'sd4096);
    send_pixel(16'sd4096, 16'sd0, 16'sd4096);
    // Hue on the 10 degree border, and on the 350 degree border.
    send_pixel(16'sd97, 16'sd17, 16'sd0);
    send_pixel(16'sd97, 16'sd0, 16'sd17);
    // Exact halves: 7.5 rounds up to 8, 2.5 rounds down to 2.
    send_pixel(16'sd65, 16'sd17, 16'sd0);
    send_pixel(16'sd193, 16'sd17, 16'sd0);
    // Just under the top of the circle rounds to 180.
    send_pixel(16'sd4096, 16'sd0, 16'sd17);
  endtask

  // Every other color, each with a pixel on the 10 degree border.
  task automatic test_color_ranges();
    for (int c = COLOR_ORANGE; c <= COLOR_UNKNOWN; c++) begin
      settle_pipeline();
      write_reg(CFG_COLOR_SELECT, 3'(c));
      send_pixel(16'sd97, 16'sd17, 16'sd0);
    end
  endtask

  // Too few channels force a zero result; spare indexes must change nothing.
  task automatic test_channel_counts();
    for (int n = 0; n < MIN_CHANNELS; n++) begin
      settle_pipeline();
      write_reg(CFG_CHANNEL_COUNT, 3'(n));
      send_pixel(16'sd4096, 16'sd2048, 16'sd0);
    end
    settle_pipeline();
    write_reg(CFG_CHANNEL_COUNT, MIN_CHANNELS);
    write_reg(CFG_SPARE_LO, COLOR_YELLOW);
    write_reg(CFG_SPARE_HI, 3'd0);
    send_pixel(16'sd4096, 16'sd4096, 16'sd0);
  endtask

  // Random pixels over a series of register settings, with idling on both sides.
  task automatic test_random_sweep();
    channel_t r, g, b;
    logic [CFG_DATA_W-1:0] phase_color, phase_count;
    int phase;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (phase = 0; phase < 12; phase++) begin
      settle_pipeline();
      phase_color = (phase < 8) ? phase[2:0] : 3'($urandom_range(0, 7));
      case (phase)
        8:  phase_count = 3'd0;
        9:  phase_count = 3'd7;
        10: phase_count = 3'd2;
        11: phase_count = 3'($urandom_range(5, 6));
        default: phase_count = 3'($urandom_range(3, 4));
      endcase
      write_reg(CFG_COLOR_SELECT, phase_color);
      write_reg(CFG_CHANNEL_COUNT, phase_count);
      repeat ((phase_count < MIN_CHANNELS) ? 40 : 160) begin
        pick_pixel(r, g, b);
        send_pixel(r, g, b);
      end
    end
  endtask

  // The receiver holds off long enough that the pipeline fills and stalls input.
  task automatic test_output_hold();
    channel_t r, g, b;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    hold_request = 80;
    repeat (48) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Closing stretch at full rate with no idling on either side.
  task automatic test_full_rate();
    channel_t r, g, b;
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    repeat (100) begin
      pick_pixel(r, g, b);
      send_pixel(r, g, b);
    end
  endtask

  // Receiver pacing: a requested long hold first, then random stall bursts.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_request--;
      out_mask.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_mask.ready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 17);
      out_mask.ready <= 1'b0;
    end else begin
      out_mask.ready <= 1'b1;
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    mask_result_t want;
    if (rst_n && out_mask.valid && out_mask.ready) begin
      if (pending_masks.size() == 0) begin
        $display("%0t: unexpected result, mask_bit %0b hue_half_degrees %0d", $time,
                 out_mask.mask_bit, out_mask.hue_half_degrees);
        mismatch_count++;
      end else begin
        want = pending_masks.pop_front();
        if (out_mask.mask_bit !== want.hit) begin
          $display("%0t: mask_bit expected %0b, actual %0b", $time, want.hit,
                   out_mask.mask_bit);
          mismatch_count++;
        end
        if (out_mask.hue_half_degrees !== want.hue) begin
          $display("%0t: hue_half_degrees expected %0d, actual %0d", $time, want.hue,
                   out_mask.hue_half_degrees);
          mismatch_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    in_pix.valid       = 1'b0;
    in_pix.red_level   = '0;
    in_pix.green_level = '0;
    in_pix.blue_level  = '0;
    out_mask.ready     = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_COLOR_SELECT;
    cfg_wdata          = '0;
    rst_n              = 1'b0;
    gaps_on            = 1'b0;
    stalls_on          = 1'b0;
    hold_request       = 0;
    stall_left         = 0;
    mismatch_count     = 0;
    color_now          = COLOR_RESET;
    channels_now       = CHANNEL_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_color_ranges();
    test_channel_counts();
    test_random_sweep();
    test_output_hold();
    test_full_rate();
    settle_pipeline();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
